// File: rtl/core/bas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_pkg
// Shared types, codes and defaults for the bounded array stack/bag block.
// ----------------------------------------------------------------------------
package bas_pkg;

  localparam int DEPTH_DEF  = 256;
  localparam int DATA_W_DEF = 32;

  localparam int OP_W     = 4;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH         = 4'd0,
    OP_GET          = 4'd1,
    OP_PUT          = 4'd2,
    OP_SWAP         = 4'd3,
    OP_REMOVE_AT    = 4'd4,
    OP_POP          = 4'd5,
    OP_TOP          = 4'd6,
    OP_CONTAINS     = 4'd7,
    OP_REMOVE_VALUE = 4'd8,
    OP_CLEAR        = 4'd9
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_EMPTY = 2'd2,
    STS_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   pos_a;
    logic [POS_W-1:0]   pos_b;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic                found;
    logic [COUNT_W-1:0]  count;
  } out_item_t;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_PA   = 2'd1,
    IDX_ZERO = 2'd2,
    IDX_INC  = 2'd3
  } idx_sel_t;

  typedef enum logic [2:0] {
    RD_NONE = 3'd0,
    RD_PA   = 3'd1,
    RD_PB   = 3'd2,
    RD_TOP  = 3'd3,
    RD_ZERO = 3'd4,
    RD_IDX1 = 3'd5,
    RD_IDX2 = 3'd6
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE   = 3'd0,
    WR_PUSH   = 3'd1,
    WR_PUT    = 3'd2,
    WR_SWAP_A = 3'd3,
    WR_SWAP_B = 3'd4,
    WR_SHIFT  = 3'd5
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_t;

  typedef struct packed {
    logic     load;
    idx_sel_t idx_sel;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    logic     tmp_ld;
    cnt_op_t  cnt_op;
    logic     finish;
    status_t  fin_status;
    logic     fin_rd;
    logic     fin_found;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            cnt_zero;
    logic            cnt_full;
    logic            pa_oor;
    logic            pb_oor;
    logic            match;
    logic            idx1_lt;
    logic            idx2_lt;
  } dp_sts_t;

endpackage

// File: rtl/core/bas_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_dpath
// Element memory, count, walk index, read/temp registers and result register.
// ----------------------------------------------------------------------------
module bas_dpath #(
  parameter int DEPTH  = bas_pkg::DEPTH_DEF,
  parameter int DATA_W = bas_pkg::DATA_W_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bas_pkg::in_item_t   in_item,
  input  bas_pkg::dp_cmd_t    cmd,
  output bas_pkg::dp_sts_t    sts,
  output bas_pkg::out_item_t  out_item
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int CW1 = CW + 1;
  localparam int PW  = (CW > bas_pkg::POS_W) ? CW : bas_pkg::POS_W;

  logic [DATA_W-1:0] mem [DEPTH];

  bas_pkg::in_item_t  item_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [DATA_W-1:0]  rd_data_r;
  logic [DATA_W-1:0]  tmp_r;
  bas_pkg::out_item_t out_r;

  logic [DATA_W-1:0] val;
  logic [CW1-1:0]    idx1, idx2;
  logic [CW-1:0]     count_m1;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  assign val      = DATA_W'(item_r.value);
  assign idx1     = CW1'(idx_r) + CW1'(1);
  assign idx2     = CW1'(idx_r) + CW1'(2);
  assign count_m1 = count_r - CW'(1);

  assign sts.op       = item_r.op;
  assign sts.cnt_zero = (count_r == '0);
  assign sts.cnt_full = (count_r == CW'(DEPTH));
  assign sts.pa_oor   = (PW'(item_r.pos_a) >= PW'(count_r));
  assign sts.pb_oor   = (PW'(item_r.pos_b) >= PW'(count_r));
  assign sts.match    = (rd_data_r == val);
  assign sts.idx1_lt  = (idx1 < CW1'(count_r));
  assign sts.idx2_lt  = (idx2 < CW1'(count_r));

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (cmd.rd_sel)
      bas_pkg::RD_NONE: rd_en = 1'b0;
      bas_pkg::RD_PA:   rd_addr = AW'(item_r.pos_a);
      bas_pkg::RD_PB:   rd_addr = AW'(item_r.pos_b);
      bas_pkg::RD_TOP:  rd_addr = count_m1[AW-1:0];
      bas_pkg::RD_ZERO: rd_addr = '0;
      bas_pkg::RD_IDX1: rd_addr = idx1[AW-1:0];
      bas_pkg::RD_IDX2: rd_addr = idx2[AW-1:0];
      default:          rd_en = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = val;
    case (cmd.wr_sel)
      bas_pkg::WR_NONE:   wr_en = 1'b0;
      bas_pkg::WR_PUSH:   wr_addr = count_r[AW-1:0];
      bas_pkg::WR_PUT:    wr_addr = AW'(item_r.pos_a);
      bas_pkg::WR_SWAP_A: begin
        wr_addr = AW'(item_r.pos_a);
        wr_data = rd_data_r;
      end
      bas_pkg::WR_SWAP_B: begin
        wr_addr = AW'(item_r.pos_b);
        wr_data = tmp_r;
      end
      bas_pkg::WR_SHIFT: begin
        wr_addr = idx_r[AW-1:0];
        wr_data = rd_data_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      bas_pkg::CNT_HOLD: count_nxt = count_r;
      bas_pkg::CNT_INC:  count_nxt = count_r + CW'(1);
      bas_pkg::CNT_DEC:  count_nxt = count_m1;
      bas_pkg::CNT_CLR:  count_nxt = '0;
      default:           count_nxt = count_r;
    endcase
  end

  always_comb begin
    case (cmd.idx_sel)
      bas_pkg::IDX_HOLD: idx_nxt = idx_r;
      bas_pkg::IDX_PA:   idx_nxt = CW'(item_r.pos_a);
      bas_pkg::IDX_ZERO: idx_nxt = '0;
      bas_pkg::IDX_INC:  idx_nxt = idx_r + CW'(1);
      default:           idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.tmp_ld) begin
      tmp_r <= rd_data_r;
    end
    if (cmd.finish) begin
      out_r.status     <= cmd.fin_status;
      out_r.read_value <= cmd.fin_rd ? bas_pkg::VALUE_W'(rd_data_r) : '0;
      out_r.found      <= cmd.fin_found;
      out_r.count      <= bas_pkg::COUNT_W'(count_nxt);
    end
  end

  assign out_item = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_sel == bas_pkg::WR_SHIFT) |-> (idx1 < CW1'(count_r)))
    else $error("shift write outside stored range");

endmodule

// File: rtl/core/bas_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_ctrl
// Operation sequencer: checks, memory walk steps and result strobe.
// ----------------------------------------------------------------------------
module bas_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_valid,
  input  bas_pkg::dp_sts_t sts,
  output bas_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_WAIT,
    ST_SW1,
    ST_SW2,
    ST_SW3,
    ST_SRCH,
    ST_SH_PRIME,
    ST_SH_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   rm_value;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign rm_value  = (sts.op == bas_pkg::OP_REMOVE_VALUE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.op inside {[bas_pkg::OP_GET:bas_pkg::OP_REMOVE_VALUE]} && sts.cnt_zero) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = bas_pkg::STS_EMPTY;
          state_nxt      = ST_IDLE;
        end else begin
          case (sts.op)
            bas_pkg::OP_PUSH: begin
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
              if (sts.cnt_full) begin
                cmd.fin_status = bas_pkg::STS_FULL;
              end else begin
                cmd.wr_sel = bas_pkg::WR_PUSH;
                cmd.cnt_op = bas_pkg::CNT_INC;
              end
            end
            bas_pkg::OP_GET: begin
              if (sts.pa_oor) begin
                cmd.finish     = 1'b1;
                cmd.fin_status = bas_pkg::STS_RANGE;
                state_nxt      = ST_IDLE;
              end else begin
                cmd.rd_sel = bas_pkg::RD_PA;
                state_nxt  = ST_RD_WAIT;
              end
            end
            bas_pkg::OP_PUT: begin
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
              if (sts.pa_oor) begin
                cmd.fin_status = bas_pkg::STS_RANGE;
              end else begin
                cmd.wr_sel = bas_pkg::WR_PUT;
              end
            end
            bas_pkg::OP_SWAP: begin
              if (sts.pa_oor || sts.pb_oor) begin
                cmd.finish     = 1'b1;
                cmd.fin_status = bas_pkg::STS_RANGE;
                state_nxt      = ST_IDLE;
              end else begin
                cmd.rd_sel = bas_pkg::RD_PA;
                state_nxt  = ST_SW1;
              end
            end
            bas_pkg::OP_REMOVE_AT: begin
              if (sts.pa_oor) begin
                cmd.finish     = 1'b1;
                cmd.fin_status = bas_pkg::STS_RANGE;
                state_nxt      = ST_IDLE;
              end else begin
                cmd.idx_sel = bas_pkg::IDX_PA;
                state_nxt   = ST_SH_PRIME;
              end
            end
            bas_pkg::OP_POP: begin
              cmd.cnt_op = bas_pkg::CNT_DEC;
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
            end
            bas_pkg::OP_TOP: begin
              cmd.rd_sel = bas_pkg::RD_TOP;
              state_nxt  = ST_RD_WAIT;
            end
            bas_pkg::OP_CONTAINS, bas_pkg::OP_REMOVE_VALUE: begin
              cmd.idx_sel = bas_pkg::IDX_ZERO;
              cmd.rd_sel  = bas_pkg::RD_ZERO;
              state_nxt   = ST_SRCH;
            end
            bas_pkg::OP_CLEAR: begin
              cmd.cnt_op = bas_pkg::CNT_CLR;
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
            end
            default: begin
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
            end
          endcase
        end
      end
      ST_RD_WAIT: begin
        cmd.finish = 1'b1;
        cmd.fin_rd = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SW1: begin
        cmd.tmp_ld = 1'b1;
        cmd.rd_sel = bas_pkg::RD_PB;
        state_nxt  = ST_SW2;
      end
      ST_SW2: begin
        cmd.wr_sel = bas_pkg::WR_SWAP_A;
        state_nxt  = ST_SW3;
      end
      ST_SW3: begin
        cmd.wr_sel = bas_pkg::WR_SWAP_B;
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SRCH: begin
        if (sts.match) begin
          if (rm_value) begin
            state_nxt = ST_SH_PRIME;
          end else begin
            cmd.finish    = 1'b1;
            cmd.fin_found = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (sts.idx1_lt) begin
          cmd.rd_sel  = bas_pkg::RD_IDX1;
          cmd.idx_sel = bas_pkg::IDX_INC;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_SH_PRIME: begin
        if (sts.idx1_lt) begin
          cmd.rd_sel = bas_pkg::RD_IDX1;
          state_nxt  = ST_SH_RUN;
        end else begin
          cmd.cnt_op    = bas_pkg::CNT_DEC;
          cmd.finish    = 1'b1;
          cmd.fin_found = rm_value;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SH_RUN: begin
        cmd.wr_sel  = bas_pkg::WR_SHIFT;
        cmd.idx_sel = bas_pkg::IDX_INC;
        if (sts.idx2_lt) begin
          cmd.rd_sel = bas_pkg::RD_IDX2;
        end else begin
          cmd.cnt_op    = bas_pkg::CNT_DEC;
          cmd.finish    = 1'b1;
          cmd.fin_found = rm_value;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while sequencer active");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid_r))
    else $error("accepted transaction did not start");

endmodule

// File: rtl/core/bounded_array_stack_bag_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_stack_bag_top
// Bounded array store with push/pop/top/get/put/swap/remove/clear and bag search.
//
//   channel  | ports                 | handshake
//   ---------+-----------------------+-------------------------------------
//   input    | start, busy, in_item  | taken when start && !busy
//   result   | out_valid, out_item   | one-cycle strobe, no backpressure
//
// push, put, pop, clear and error results finish in the decode state.
// get and top add a registered memory read; swap reads both entries and
// writes them back in turn. remove_at shifts the entries above pos down;
// contains/remove_value walk the memory one entry a cycle, set by the
// single read port of the element memory.
// A new transaction is taken in the cycle its predecessor's result strobes.
// Synchronous active-low reset empties the store; memory contents are not
// cleared. The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
module bounded_array_stack_bag_top #(
  parameter int DEPTH  = bas_pkg::DEPTH_DEF,
  parameter int DATA_W = bas_pkg::DATA_W_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bas_pkg::in_item_t  in_item,
  output logic               out_valid,
  output bas_pkg::out_item_t out_item
);

  bas_pkg::dp_cmd_t cmd;
  bas_pkg::dp_sts_t sts;

  bas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  bas_dpath #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule
